@@ design/bfa_pkg.sv @@
`default_nettype none
package bfa_pkg;

  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_TRIM  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOTHING = 2'd3;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_CHUNK  = 1'b1;

  localparam logic [7:0]  HDR_RESET   = 8'd24;
  localparam logic [31:0] CHUNK_RESET = 32'd131072;
  localparam logic [31:0] LEN_MAX     = 32'hFFFF_FFFF;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;
  localparam logic [7:0]  COUNT_KNEE  = 8'd254;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LOAD     = 4'd1,
    CMD_DISPATCH = 4'd2,
    CMD_SCAN     = 4'd3,
    CMD_DECIDE   = 4'd4,
    CMD_DIVIDE   = 4'd5,
    CMD_DROP     = 4'd6,
    CMD_INSERT   = 4'd7,
    CMD_EMIT     = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       seq_done;
    logic       take_ok;
    logic       div_done;
    logic       need_put;
    logic       placed;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/bfa_ctrl.sv @@
`default_nettype none
module bfa_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                logic out_ready_i,
  input  bfa_pkg::dp_stat_t  stat_i,
  output bfa_pkg::cmd_e      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_DIVIDE   = 8'b0001_0000,
    S_DROP     = 8'b0010_0000,
    S_INSERT   = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  always_comb begin
    state_d = state_q;
    cmd_o   = bfa_pkg::CMD_NONE;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = bfa_pkg::CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o = bfa_pkg::CMD_DISPATCH;
        if (stat_i.op == bfa_pkg::OP_FREE) begin
          state_d = stat_i.full ? S_FINISH : S_INSERT;
        end else if ((stat_i.op == bfa_pkg::OP_ALLOC || stat_i.op == bfa_pkg::OP_TRIM)
                     && !stat_i.empty) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o = bfa_pkg::CMD_SCAN;
        if (stat_i.seq_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o = bfa_pkg::CMD_DECIDE;
        if (!stat_i.take_ok) begin
          state_d = S_FINISH;
        end else begin
          state_d = (stat_i.op == bfa_pkg::OP_TRIM) ? S_DIVIDE : S_DROP;
        end
      end
      S_DIVIDE: begin
        cmd_o = bfa_pkg::CMD_DIVIDE;
        if (stat_i.div_done) state_d = S_DROP;
      end
      S_DROP: begin
        cmd_o = bfa_pkg::CMD_DROP;
        if (stat_i.seq_done) state_d = stat_i.need_put ? S_INSERT : S_FINISH;
      end
      S_INSERT: begin
        cmd_o = bfa_pkg::CMD_INSERT;
        if (stat_i.placed) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o   = bfa_pkg::CMD_EMIT;
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ design/bfa_datapath.sv @@
`default_nettype none
module bfa_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 32
) (
  input  wire               logic        clk_i,
  input  wire               logic        rst_ni,
  input  wire               logic [1:0]  opcode_i,
  input  wire               logic [31:0] block_address_i,
  input  wire               logic [31:0] size_bytes_i,
  input  wire               logic        cfg_valid_i,
  input  wire               logic        cfg_index_i,
  input  wire               logic [31:0] cfg_data_i,
  input  bfa_pkg::cmd_e     cmd_i,
  output bfa_pkg::dp_stat_t stat_o,
  output logic [1:0]        status_o,
  output logic [31:0]       payload_address_o,
  output logic [7:0]        release_count_o
);

  localparam int AW  = ADDRESS_BITS;
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int SW  = 33 + $clog2(TABLE_ENTRIES);
  localparam int DCW = $clog2(SW + 1);

  logic [7:0]    hdr_q;
  logic [31:0]   chunk_q;
  logic [1:0]    op_q;
  logic [31:0]   addr_q, size_q;
  logic [CW-1:0] count_q;

  logic [AW-1:0] st_mem [TABLE_ENTRIES];
  logic [31:0]   ln_mem [TABLE_ENTRIES];
  logic [AW-1:0] rd_st_q;
  logic [31:0]   rd_ln_q;

  logic [IW-1:0] rd_ptr_q, dix_q, wr_ptr_q;
  logic [CW-1:0] rd_left_q;
  logic          dv_q, placed_q;

  logic          scan_first_q;
  logic [AW-1:0] prev_st_q;
  logic [31:0]   prev_ln_q;
  logic [SW-1:0] run_sum_q, best_sum_q;
  logic [CW-1:0] run_n_q, best_n_q, drop_n_q;
  logic [IW-1:0] run_first_q, best_first_q, one_idx_q;
  logic [AW-1:0] run_base_q, best_base_q, one_base_q;
  logic          have_run_q, have_one_q;
  logic [31:0]   one_len_q;

  logic [AW-1:0] put_start_q;
  logic [31:0]   put_len_q;
  logic          need_put_q;

  logic [DCW-1:0] div_cnt_q;
  logic [31:0]    div_r_q;
  logic [SW-1:0]  div_dvd_q;
  logic [7:0]     qs_q;

  logic [1:0]  res_status_q, out_status_q;
  logic [31:0] res_payload_q, out_payload_q;
  logic [7:0]  res_count_q, out_count_q;

  logic [AW-1:0] hdr_a;
  logic [31:0]   chunk_w;
  logic          full, empty, is_alloc, seq_done;

  logic          adj, rec, one_hit;
  logic [SW-1:0] nsum;
  logic [CW-1:0] nn;
  logic [IW-1:0] nfirst;
  logic [AW-1:0] nbase;

  logic          use_run, take_ok;
  logic [IW-1:0] tk_first;
  logic [CW-1:0] tk_n;
  logic [SW-1:0] tk_total;
  logic [AW-1:0] tk_base;
  logic [SW-1:0] alloc_rem, alloc_lt, trim_dvd;
  logic          alloc_need;
  logic [31:0]   alloc_len;
  logic [CW:0]   drop_rd;
  logic [CW-1:0] drop_left, newc;

  logic [32:0]   r_sh;
  logic          ge;
  logic [31:0]   r_n;
  logic [8:0]    q2;
  logic [7:0]    qs_d;
  logic [31:0]   rem_t;
  logic [7:0]    count_t;

  logic          rd_phase, rd_down, rd_en, ins_stop, ins_place;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_st;
  logic [31:0]   wr_ln;

  assign hdr_a    = AW'(hdr_q);
  assign chunk_w  = (chunk_q == 32'd0) ? 32'd1 : chunk_q;
  assign full     = (count_q == CW'(TABLE_ENTRIES));
  assign empty    = (count_q == '0);
  assign is_alloc = (op_q == bfa_pkg::OP_ALLOC);
  assign seq_done = (rd_left_q == '0) && !dv_q;

  always_comb begin
    adj = !scan_first_q && ((prev_st_q + AW'(prev_ln_q) + hdr_a) == rd_st_q);
    if (adj) begin
      nsum   = run_sum_q + SW'(rd_ln_q) + SW'(hdr_q);
      nn     = run_n_q + CW'(1);
      nfirst = run_first_q;
      nbase  = run_base_q;
    end else begin
      nsum   = SW'(rd_ln_q);
      nn     = CW'(1);
      nfirst = dix_q;
      nbase  = rd_st_q;
    end
    rec     = is_alloc && (nn > CW'(1)) && (nsum >= SW'(size_q))
              && (!have_run_q || nsum < best_sum_q);
    one_hit = (rd_ln_q >= size_q) && (!have_one_q || rd_ln_q < one_len_q);
  end

  always_comb begin
    use_run = have_run_q && (!have_one_q || best_sum_q < SW'(one_len_q));
    if (is_alloc) begin
      take_ok  = have_run_q || have_one_q;
      tk_first = use_run ? best_first_q : one_idx_q;
      tk_n     = use_run ? best_n_q : CW'(1);
      tk_total = use_run ? best_sum_q : SW'(one_len_q);
      tk_base  = use_run ? best_base_q : one_base_q;
    end else begin
      take_ok  = run_sum_q > SW'(chunk_w);
      tk_first = run_first_q;
      tk_n     = run_n_q;
      tk_total = run_sum_q;
      tk_base  = run_base_q;
    end
    alloc_rem  = tk_total - SW'(size_q);
    alloc_need = alloc_rem > SW'(hdr_q);
    alloc_lt   = alloc_rem - SW'(hdr_q);
    alloc_len  = (alloc_lt > SW'(bfa_pkg::LEN_MAX)) ? bfa_pkg::LEN_MAX : alloc_lt[31:0];
    trim_dvd   = run_sum_q - SW'(chunk_w) - SW'(1);
    drop_rd    = (CW+1)'(tk_first) + (CW+1)'(tk_n);
    drop_left  = count_q - CW'(tk_first) - tk_n;
    newc       = count_q - drop_n_q;
  end

  always_comb begin
    r_sh    = {div_r_q, div_dvd_q[SW-1]};
    ge      = (r_sh >= {1'b0, chunk_w});
    r_n     = ge ? 32'(r_sh - {1'b0, chunk_w}) : r_sh[31:0];
    q2      = {qs_q, ge};
    qs_d    = q2[8] ? bfa_pkg::COUNT_MAX : q2[7:0];
    rem_t   = div_r_q + 32'd1;
    count_t = (qs_q >= bfa_pkg::COUNT_KNEE) ? bfa_pkg::COUNT_MAX : qs_q + 8'd1;
  end

  always_comb begin
    rd_phase  = (cmd_i == bfa_pkg::CMD_SCAN) || (cmd_i == bfa_pkg::CMD_DROP)
                || (cmd_i == bfa_pkg::CMD_INSERT);
    rd_down   = (cmd_i == bfa_pkg::CMD_INSERT);
    ins_stop  = rd_down && !placed_q && dv_q && !(rd_st_q > put_start_q);
    ins_place = rd_down && !placed_q && (ins_stop || (!dv_q && rd_left_q == '0));
    rd_en     = rd_phase && (rd_left_q != '0) && !placed_q && !ins_stop;
    wr_en     = 1'b0;
    wr_idx    = wr_ptr_q;
    wr_st     = rd_st_q;
    wr_ln     = rd_ln_q;
    if (cmd_i == bfa_pkg::CMD_DROP) begin
      wr_en = dv_q;
    end else if (rd_down && !placed_q) begin
      if (dv_q) begin
        wr_en  = 1'b1;
        wr_idx = dix_q + IW'(1);
        if (ins_stop) begin
          wr_st = put_start_q;
          wr_ln = put_len_q;
        end
      end else if (rd_left_q == '0) begin
        wr_en  = 1'b1;
        wr_idx = '0;
        wr_st  = put_start_q;
        wr_ln  = put_len_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      st_mem[wr_idx] <= wr_st;
      ln_mem[wr_idx] <= wr_ln;
    end
    if (rd_en) begin
      rd_st_q <= st_mem[rd_ptr_q];
      rd_ln_q <= ln_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= bfa_pkg::HDR_RESET;
      chunk_q <= bfa_pkg::CHUNK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfa_pkg::REG_HEADER: hdr_q   <= cfg_data_i[7:0];
        bfa_pkg::REG_CHUNK:  chunk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_left_q <= '0;
      rd_ptr_q  <= '0;
      dix_q     <= '0;
      dv_q      <= 1'b0;
      placed_q  <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (rd_en) begin
        rd_left_q <= rd_left_q - CW'(1);
        rd_ptr_q  <= rd_down ? rd_ptr_q - IW'(1) : rd_ptr_q + IW'(1);
        dix_q     <= rd_ptr_q;
        dv_q      <= 1'b1;
      end else begin
        dv_q <= 1'b0;
      end
      if (ins_stop) rd_left_q <= '0;
      if (ins_place) begin
        placed_q <= 1'b1;
        count_q  <= count_q + CW'(1);
      end
      case (cmd_i)
        bfa_pkg::CMD_DISPATCH: begin
          placed_q  <= 1'b0;
          rd_left_q <= count_q;
          rd_ptr_q  <= (op_q == bfa_pkg::OP_FREE) ? IW'(count_q - CW'(1)) : '0;
        end
        bfa_pkg::CMD_DECIDE: begin
          rd_ptr_q  <= IW'(drop_rd);
          rd_left_q <= drop_left;
          div_cnt_q <= DCW'(SW);
        end
        bfa_pkg::CMD_DIVIDE: begin
          if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - DCW'(1);
        end
        bfa_pkg::CMD_DROP: begin
          if (seq_done) begin
            count_q   <= newc;
            rd_ptr_q  <= IW'(newc - CW'(1));
            rd_left_q <= newc;
            placed_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bfa_pkg::CMD_LOAD: begin
        op_q   <= opcode_i;
        addr_q <= block_address_i;
        size_q <= size_bytes_i;
      end
      bfa_pkg::CMD_DISPATCH: begin
        scan_first_q  <= 1'b1;
        have_one_q    <= 1'b0;
        have_run_q    <= 1'b0;
        run_sum_q     <= '0;
        run_n_q       <= '0;
        put_start_q   <= AW'(addr_q) - hdr_a;
        put_len_q     <= size_q;
        res_payload_q <= '0;
        res_count_q   <= '0;
        case (op_q)
          bfa_pkg::OP_FREE:  res_status_q <= full ? bfa_pkg::ST_FULL : bfa_pkg::ST_OK;
          bfa_pkg::OP_ALLOC: res_status_q <= empty ? bfa_pkg::ST_NO_FIT : bfa_pkg::ST_OK;
          bfa_pkg::OP_TRIM:  res_status_q <= empty ? bfa_pkg::ST_NOTHING : bfa_pkg::ST_OK;
          default:           res_status_q <= bfa_pkg::ST_OK;
        endcase
      end
      bfa_pkg::CMD_SCAN: begin
        if (dv_q) begin
          prev_st_q    <= rd_st_q;
          prev_ln_q    <= rd_ln_q;
          scan_first_q <= 1'b0;
          if (rec) begin
            have_run_q   <= 1'b1;
            best_sum_q   <= nsum;
            best_n_q     <= nn;
            best_first_q <= nfirst;
            best_base_q  <= nbase;
            run_sum_q    <= SW'(rd_ln_q);
            run_n_q      <= CW'(1);
            run_first_q  <= dix_q;
            run_base_q   <= rd_st_q;
          end else begin
            run_sum_q    <= nsum;
            run_n_q      <= nn;
            run_first_q  <= nfirst;
            run_base_q   <= nbase;
          end
          if (is_alloc && one_hit) begin
            have_one_q <= 1'b1;
            one_len_q  <= rd_ln_q;
            one_idx_q  <= dix_q;
            one_base_q <= rd_st_q;
          end
        end
      end
      bfa_pkg::CMD_DECIDE: begin
        wr_ptr_q  <= tk_first;
        drop_n_q  <= tk_n;
        div_r_q   <= '0;
        div_dvd_q <= trim_dvd;
        qs_q      <= '0;
        if (is_alloc) begin
          put_start_q <= tk_base + AW'(size_q) + hdr_a;
          put_len_q   <= alloc_len;
          need_put_q  <= alloc_need;
          if (take_ok) res_payload_q <= 32'(tk_base + hdr_a);
          else         res_status_q  <= bfa_pkg::ST_NO_FIT;
        end else begin
          put_start_q <= tk_base;
          if (!take_ok) res_status_q <= bfa_pkg::ST_NOTHING;
        end
      end
      bfa_pkg::CMD_DIVIDE: begin
        if (div_cnt_q != '0) begin
          div_r_q   <= r_n;
          div_dvd_q <= {div_dvd_q[SW-2:0], 1'b0};
          qs_q      <= qs_d;
        end else begin
          put_len_q   <= rem_t;
          need_put_q  <= rem_t > 32'(hdr_q);
          res_count_q <= count_t;
        end
      end
      bfa_pkg::CMD_DROP: begin
        if (dv_q) wr_ptr_q <= wr_ptr_q + IW'(1);
      end
      bfa_pkg::CMD_EMIT: begin
        out_status_q  <= res_status_q;
        out_payload_q <= res_payload_q;
        out_count_q   <= res_count_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.op       = op_q;
    stat_o.full     = full;
    stat_o.empty    = empty;
    stat_o.seq_done = seq_done;
    stat_o.take_ok  = take_ok;
    stat_o.div_done = (div_cnt_q == '0);
    stat_o.need_put = need_put_q;
    stat_o.placed   = placed_q;
  end

  assign status_o          = out_status_q;
  assign payload_address_o = out_payload_q;
  assign release_count_o   = out_count_q;

endmodule
`default_nettype wire

@@ design/best_fit_free_extent_allocator.sv @@
// Trim uses a restoring divider over SW = 33+clog2(TABLE_ENTRIES) dividend bits.
// Throughput: one operation at a time; each pass walks the extent memory one entry
// per cycle through its single read port. A result waits in an output register.
// Reset: asynchronous, active low; empties the table and restores both registers.
`default_nettype none
module best_fit_free_extent_allocator #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 32
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic [1:0]  opcode_i,
  input  wire  logic [31:0] block_address_i,
  input  wire  logic [31:0] size_bytes_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [1:0]        status_o,
  output logic [31:0]       payload_address_o,
  output logic [7:0]        release_count_o,
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic        cfg_index_i,
  input  wire  logic [31:0] cfg_data_i
);

  bfa_pkg::cmd_e     cmd;
  bfa_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfa_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .block_address_i   (block_address_i),
    .size_bytes_i      (size_bytes_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .release_count_o   (release_count_o)
  );

endmodule
`default_nettype wire
